>>> src/cpbd_pkg.sv
// ----------------------------------------------------------------------------
// cpbd_pkg
// Shared types and constants for the cassette pulse block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cpbd_pkg;

  localparam int CFG_DATA_W = 16;

  // threshold divider 0x0180 = 3 << 7
  localparam int DIV_SHIFT = 7;

  localparam logic [7:0]  TAPEMARK_LENGTH_RESET = 8'd40;
  localparam logic [15:0] BLOCK_SIZE_RESET      = 16'd128;

  typedef enum logic [0:0] {
    CFG_TAPEMARK_LENGTH,
    CFG_BLOCK_SIZE
  } cpbd_cfg_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_GOOD,
    KIND_MISMATCH,
    KIND_NO_START
  } cpbd_kind_t;

  typedef enum logic [2:0] {
    F_SKIP,
    F_SYNC,
    F_MARK_ONES,
    F_MARK_ZEROS,
    F_MARK_END,
    F_DATA
  } cpbd_fphase_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DATA,
    B_CSUM_HI,
    B_CSUM_LO
  } cpbd_bphase_t;

  typedef struct packed {
    logic sample;
    logic restart;
  } cpbd_in_t;

  typedef struct packed {
    cpbd_kind_t  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] ones_count;
    logic        last;
  } cpbd_out_t;

  // front to back: either a data-start marker or one classified pulse
  typedef struct packed {
    logic start;
    logic bit_val;
  } cpbd_tok_t;

endpackage

`default_nettype wire

>>> src/cpbd_front.sv
// ----------------------------------------------------------------------------
// cpbd_front
// Pulse measurement, threshold training and tapemark search; emits pulse
// tokens once data starts.
// ----------------------------------------------------------------------------
`default_nettype none

module cpbd_front #(
  parameter int SKIP_PULSES = 256,
  parameter int SYNC_WINDOW = 512,
  parameter int LENGTH_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cpbd_pkg::cpbd_in_t  in_data,
  input  logic [7:0]          tapemark_length,
  input  logic                q_full,
  output logic                push,
  output cpbd_pkg::cpbd_tok_t push_tok
);
  import cpbd_pkg::*;

  localparam int CNT_MAX = (SKIP_PULSES > SYNC_WINDOW) ? SKIP_PULSES : SYNC_WINDOW;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int SUM_W   = LENGTH_BITS + $clog2(SYNC_WINDOW);
  localparam int Q_W     = SUM_W - DIV_SHIFT;
  localparam int K       = Q_W + 2;
  localparam int P_W     = Q_W + K;
  localparam int CMP_W   = (Q_W > LENGTH_BITS) ? Q_W : LENGTH_BITS;
  localparam logic [K-1:0] RECIP = K'(((64'd1 << K) + 64'd2) / 64'd3);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  cpbd_fphase_t           phase_r, phase_nxt, ph_c;
  logic [LENGTH_BITS-1:0] hl_r, hl_nxt, hl_c;
  logic                   low_r, low_nxt, low_c;
  logic [CNT_W-1:0]       pc_r, pc_nxt, pc_c, pc_inc;
  logic [SUM_W-1:0]       sum_r, sum_nxt, sum_c, sum_add;
  logic [LENGTH_BITS-1:0] thr_r, thr_nxt, thr_c;
  logic [7:0]             mc_r, mc_nxt, mc_c;
  logic                   div_pend_r, div_pend_nxt;
  logic [Q_W-1:0]         div_in_r, div_in_nxt;

  logic                   acc, clr, pulse, bit_v, resync;
  logic [7:0]             ml;
  logic [8:0]             mc_inc;
  logic                   skip_done, sync_done, ones_done, zeros_done;
  logic [P_W-1:0]         prod;
  logic [CMP_W-1:0]       q_ext;
  logic [LENGTH_BITS-1:0] div_q;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign clr      = acc && in_data.restart;

  assign ph_c  = clr ? F_SKIP : phase_r;
  assign hl_c  = clr ? '0 : hl_r;
  assign low_c = clr ? 1'b0 : low_r;
  assign pc_c  = clr ? '0 : pc_r;
  assign sum_c = clr ? '0 : sum_r;
  assign thr_c = clr ? '0 : thr_r;
  assign mc_c  = clr ? '0 : mc_r;

  assign pulse   = acc && in_data.sample && low_c;
  assign bit_v   = (thr_c != '0) && (hl_c >= thr_c);
  assign ml      = (tapemark_length == 8'd0) ? 8'd1 : tapemark_length;
  assign pc_inc  = pc_c + CNT_W'(1);
  assign mc_inc  = {1'b0, mc_c} + 9'd1;
  assign sum_add = sum_c + SUM_W'(hl_c);

  assign skip_done  = pc_inc >= CNT_W'(SKIP_PULSES);
  assign sync_done  = pc_inc >= CNT_W'(SYNC_WINDOW);
  assign ones_done  = mc_inc >= ({1'b0, ml} - 9'd1);
  assign zeros_done = mc_inc >= {1'b0, ml};

  assign resync = pulse && (((ph_c == F_MARK_ONES) && !bit_v) ||
                            ((ph_c == F_MARK_ZEROS) && bit_v) ||
                            ((ph_c == F_MARK_END) && !bit_v));

  // sum / 384: drop 7 bits, then reciprocal multiply by 1/3
  assign prod  = P_W'(div_in_r) * P_W'(RECIP);
  assign q_ext = CMP_W'(prod[P_W-1:K]);
  assign div_q = (q_ext > CMP_W'(LEN_MAX)) ? LEN_MAX : q_ext[LENGTH_BITS-1:0];

  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      phase_nxt = ph_c;
      if (pulse) begin
        case (ph_c)
          F_SKIP: begin
            if (skip_done) phase_nxt = F_SYNC;
          end
          F_SYNC: begin
            if (bit_v) phase_nxt = (ml > 8'd1) ? F_MARK_ONES : F_MARK_ZEROS;
          end
          F_MARK_ONES: begin
            if (!bit_v) phase_nxt = F_SKIP;
            else if (ones_done) phase_nxt = F_MARK_ZEROS;
          end
          F_MARK_ZEROS: begin
            if (bit_v) phase_nxt = F_SKIP;
            else if (zeros_done) phase_nxt = F_MARK_END;
          end
          F_MARK_END: begin
            phase_nxt = bit_v ? F_DATA : F_SKIP;
          end
          F_DATA: begin
            phase_nxt = F_DATA;
          end
          default: begin
            phase_nxt = F_SKIP;
          end
        endcase
      end
    end
  end

  always_comb begin
    hl_nxt       = hl_r;
    low_nxt      = low_r;
    pc_nxt       = pc_r;
    sum_nxt      = sum_r;
    thr_nxt      = thr_r;
    mc_nxt       = mc_r;
    div_pend_nxt = 1'b0;
    div_in_nxt   = div_in_r;
    push         = 1'b0;
    push_tok     = '0;
    if (div_pend_r) thr_nxt = div_q;
    if (acc) begin
      hl_nxt  = hl_c;
      low_nxt = low_c;
      pc_nxt  = pc_c;
      sum_nxt = sum_c;
      mc_nxt  = mc_c;
      if (clr) thr_nxt = '0;
      if (in_data.sample) begin
        if (low_c) begin
          low_nxt = 1'b0;
          hl_nxt  = LENGTH_BITS'(1);
        end else if (hl_c != LEN_MAX) begin
          hl_nxt = hl_c + LENGTH_BITS'(1);
        end
      end else begin
        low_nxt = 1'b1;
      end
      if (pulse) begin
        case (ph_c)
          F_SKIP: begin
            pc_nxt = pc_inc;
            if (skip_done) begin
              pc_nxt  = '0;
              sum_nxt = '0;
            end
          end
          F_SYNC: begin
            if (bit_v) begin
              mc_nxt = '0;
            end else begin
              sum_nxt = sum_add;
              pc_nxt  = pc_inc;
              if (sync_done) begin
                div_pend_nxt = 1'b1;
                div_in_nxt   = sum_add[SUM_W-1:DIV_SHIFT];
                sum_nxt      = '0;
                pc_nxt       = '0;
              end
            end
          end
          F_MARK_ONES: begin
            if (bit_v) mc_nxt = ones_done ? 8'd0 : mc_inc[7:0];
          end
          F_MARK_ZEROS: begin
            if (!bit_v) mc_nxt = zeros_done ? 8'd0 : mc_inc[7:0];
          end
          F_MARK_END: begin
            if (bit_v) begin
              push           = 1'b1;
              push_tok.start = 1'b1;
            end
          end
          F_DATA: begin
            push             = 1'b1;
            push_tok.bit_val = bit_v;
          end
          default: begin
            push = 1'b0;
          end
        endcase
      end
      if (resync) begin
        pc_nxt       = '0;
        sum_nxt      = '0;
        thr_nxt      = '0;
        div_pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= F_SKIP;
      hl_r       <= '0;
      low_r      <= 1'b0;
      pc_r       <= '0;
      sum_r      <= '0;
      thr_r      <= '0;
      mc_r       <= '0;
      div_pend_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      hl_r       <= hl_nxt;
      low_r      <= low_nxt;
      pc_r       <= pc_nxt;
      sum_r      <= sum_nxt;
      thr_r      <= thr_nxt;
      mc_r       <= mc_nxt;
      div_pend_r <= div_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_in_r <= div_in_nxt;
  end

endmodule

`default_nettype wire

>>> src/cpbd_fifo.sv
// ----------------------------------------------------------------------------
// cpbd_fifo
// Short token queue between the pulse front end and the byte back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cpbd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cpbd_pkg::cpbd_tok_t push_tok,
  output logic                full,
  output logic                tok_valid,
  output cpbd_pkg::cpbd_tok_t tok,
  input  logic                pop
);
  import cpbd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cpbd_tok_t       mem_r [DEPTH];
  logic [AW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full      = cnt_r == CW'(DEPTH);
  assign tok_valid = cnt_r != '0;
  assign tok       = mem_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && tok_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
    if (do_pop) rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_tok;
  end

endmodule

`default_nettype wire

>>> src/cpbd_back.sv
// ----------------------------------------------------------------------------
// cpbd_back
// Byte framing, one-bit count and checksum check; holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpbd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tok_valid,
  input  cpbd_pkg::cpbd_tok_t tok,
  output logic                tok_pop,
  input  logic [15:0]         blk_len,
  output logic                out_valid,
  input  logic                out_ready,
  output cpbd_pkg::cpbd_out_t out_data
);
  import cpbd_pkg::*;

  cpbd_bphase_t phase_r, phase_nxt;
  logic [3:0]   bc_r, bc_nxt, bc_inc;
  logic [15:0]  byte_cnt_r, byte_cnt_nxt, byte_cnt_inc;
  logic [7:0]   shift_r, shift_nxt, shift_new;
  logic [15:0]  ones_r, ones_nxt, ones_inc;
  logic [7:0]   csum_hi_r, csum_hi_nxt;
  logic         out_valid_r, out_valid_nxt;
  cpbd_out_t    out_data_r, out_data_nxt;

  logic         pulse, byte_done, emit_v;
  cpbd_out_t    emit_d;

  assign tok_pop      = tok_valid && (!out_valid_r || out_ready);
  assign pulse        = tok_pop && !tok.start && (phase_r != B_IDLE);
  assign shift_new    = {shift_r[6:0], tok.bit_val};
  assign ones_inc     = ones_r + 16'((phase_r == B_DATA) && tok.bit_val);
  assign bc_inc       = bc_r + 4'd1;
  assign byte_done    = (bc_r != 4'd0) && (bc_inc == 4'd9);
  assign byte_cnt_inc = byte_cnt_r + 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    if (tok_pop && tok.start) begin
      phase_nxt = (blk_len == 16'd0) ? B_CSUM_HI : B_DATA;
    end else if (pulse) begin
      if (bc_r == 4'd0) begin
        if (!tok.bit_val) phase_nxt = B_IDLE;
      end else if (byte_done) begin
        case (phase_r)
          B_DATA: begin
            if (byte_cnt_inc >= blk_len) phase_nxt = B_CSUM_HI;
          end
          B_CSUM_HI: phase_nxt = B_CSUM_LO;
          B_CSUM_LO: phase_nxt = B_IDLE;
          default:   phase_nxt = B_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    bc_nxt       = bc_r;
    byte_cnt_nxt = byte_cnt_r;
    shift_nxt    = shift_r;
    ones_nxt     = ones_r;
    csum_hi_nxt  = csum_hi_r;
    emit_v       = 1'b0;
    emit_d       = '{kind: KIND_DATA, data_byte: 8'd0, byte_index: byte_cnt_r,
                     ones_count: ones_r, last: 1'b1};
    if (tok_pop && tok.start) begin
      bc_nxt       = 4'd0;
      byte_cnt_nxt = 16'd0;
      shift_nxt    = 8'd0;
      ones_nxt     = 16'd0;
    end else if (pulse) begin
      if (bc_r == 4'd0) begin
        if (!tok.bit_val) begin
          emit_v      = 1'b1;
          emit_d.kind = KIND_NO_START;
        end else begin
          bc_nxt    = 4'd1;
          shift_nxt = 8'd0;
        end
      end else begin
        shift_nxt = shift_new;
        ones_nxt  = ones_inc;
        bc_nxt    = byte_done ? 4'd0 : bc_inc;
        if (byte_done) begin
          case (phase_r)
            B_DATA: begin
              emit_v            = 1'b1;
              emit_d.data_byte  = shift_new;
              emit_d.ones_count = ones_inc;
              emit_d.last       = 1'b0;
              byte_cnt_nxt      = byte_cnt_inc;
            end
            B_CSUM_HI: csum_hi_nxt = shift_new;
            B_CSUM_LO: begin
              emit_v      = 1'b1;
              emit_d.kind = ({csum_hi_r, shift_new} == ones_r) ? KIND_GOOD : KIND_MISMATCH;
            end
            default: emit_v = 1'b0;
          endcase
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit_v) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_d;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= B_IDLE;
      bc_r        <= '0;
      byte_cnt_r  <= '0;
      shift_r     <= '0;
      ones_r      <= '0;
      csum_hi_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      bc_r        <= bc_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      shift_r     <= shift_nxt;
      ones_r      <= ones_nxt;
      csum_hi_r   <= csum_hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> src/cassette_pulse_block_decoder_core.sv
// ----------------------------------------------------------------------------
// cassette_pulse_block_decoder_core
// Pulse-width cassette block decoder: front end, token queue, byte back end.
//
//   port group   direction   handshake            payload
//   in_          sink        in_valid/in_ready    sample, restart
//   out_         source      out_valid/out_ready  kind, data_byte, byte_index,
//                                                 ones_count, last
//   cfg_         sink        cfg_we               cfg_index, cfg_data
//
// One sample item per cycle while the token queue has room; with the queue empty
// and the result register free, the item that completes a byte or status has its
// token queued at acceptance, and the back end then loads the result register.
// Threshold update after a training window goes through the divider input
// register and reciprocal multiplier, covered by two samples per pulse minimum.
// Synchronous reset clears all control state; restart clears the front end state.
// in_ready drops only when the token queue is full behind a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module cassette_pulse_block_decoder_core #(
  parameter int SKIP_PULSES = 256,
  parameter int SYNC_WINDOW = 512,
  parameter int LENGTH_BITS = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cpbd_pkg::cpbd_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cpbd_pkg::cpbd_out_t         out_data,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [cpbd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cpbd_pkg::*;

  logic [7:0]  tml_r, tml_nxt;
  logic [15:0] bsz_r, bsz_nxt;

  logic        q_full, push, tok_valid, tok_pop;
  cpbd_tok_t   push_tok, tok;

  always_comb begin
    tml_nxt = tml_r;
    bsz_nxt = bsz_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TAPEMARK_LENGTH: tml_nxt = cfg_data[7:0];
        CFG_BLOCK_SIZE:      bsz_nxt = cfg_data[15:0];
        default:             tml_nxt = tml_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tml_r <= TAPEMARK_LENGTH_RESET;
      bsz_r <= BLOCK_SIZE_RESET;
    end else begin
      tml_r <= tml_nxt;
      bsz_r <= bsz_nxt;
    end
  end

  cpbd_front #(
    .SKIP_PULSES(SKIP_PULSES),
    .SYNC_WINDOW(SYNC_WINDOW),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .tapemark_length(tml_r),
    .q_full         (q_full),
    .push           (push),
    .push_tok       (push_tok)
  );

  cpbd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .full     (q_full),
    .tok_valid(tok_valid),
    .tok      (tok),
    .pop      (tok_pop)
  );

  cpbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop),
    .blk_len   (bsz_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> src/cpbd_checker.sv
// ----------------------------------------------------------------------------
// cpbd_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cpbd_sva (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input cpbd_pkg::cpbd_out_t out_data
);
  import cpbd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // last marks exactly the status results
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.kind != KIND_DATA)))
    else $error("last flag does not match result kind");

  // status results carry no byte
  a_status_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.data_byte == 8'd0)
    else $error("status item with nonzero data byte");

  // a block ends idle: nothing directly follows a status
  a_status_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last |=> !out_valid)
    else $error("result directly after block status");

endmodule

bind cassette_pulse_block_decoder_core cpbd_sva u_cpbd_sva (.*);

`default_nettype wire

>>> verif/cpbd_checker.sv
// ----------------------------------------------------------------------------
// cpbd_checker
// Watches the sample and result channels of the cassette pulse block decoder,
// keeps its own copy of the pulse, tapemark and byte decoding state, predicts
// every result from the accepted samples and compares each result field by
// field with the oldest prediction. Mismatch and pending counts go to the top.
// ----------------------------------------------------------------------------
module cpbd_checker import cpbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  cpbd_in_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  cpbd_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    err_count,
  output int                    pending,
  output int                    n_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SKIP_PULSES = 256;
  localparam int          SYNC_WINDOW = 512;
  localparam logic [24:0] SYNC_DIV    = 25'h180;
  localparam logic [15:0] LEN_MAX     = 16'hFFFF;

  typedef enum logic [3:0] {
    TP_SKIP,
    TP_SYNC,
    TP_MARK_ONES,
    TP_MARK_ZEROS,
    TP_MARK_END,
    TP_DATA,
    TP_CSUM_HI,
    TP_CSUM_LO,
    TP_DONE
  } tape_phase_e;

  tape_phase_e phase;
  logic [15:0] hi_len;
  logic        low_seen;
  logic [9:0]  pulse_cnt;
  logic [24:0] len_sum;
  logic [15:0] thresh;
  logic [7:0]  mark_cnt;
  logic [15:0] byte_cnt;
  logic [3:0]  bit_cnt;
  logic [7:0]  shreg;
  logic [15:0] ones_tot;
  logic [7:0]  csum_hi;

  logic [7:0]  mark_len_r;
  logic [15:0] block_len_r;

  cpbd_out_t   expected_q[$];
  int          mism;
  int          checked;

  task automatic clear_decoder();
    phase     = TP_SKIP;
    hi_len    = '0;
    low_seen  = 1'b0;
    pulse_cnt = '0;
    len_sum   = '0;
    thresh    = '0;
    mark_cnt  = '0;
    byte_cnt  = '0;
    bit_cnt   = '0;
    shreg     = '0;
    ones_tot  = '0;
    csum_hi   = '0;
  endtask

  function automatic logic [7:0] mark_len();
    return (mark_len_r == 8'd0) ? 8'd1 : mark_len_r;
  endfunction

  task automatic resync();
    phase     = TP_SKIP;
    pulse_cnt = '0;
    len_sum   = '0;
    thresh    = '0;
  endtask

  task automatic push_result(input cpbd_kind_t k, input logic [7:0] b, input logic l);
    cpbd_out_t r;
    r.kind       = k;
    r.data_byte  = b;
    r.byte_index = byte_cnt;
    r.ones_count = ones_tot;
    r.last       = l;
    expected_q.push_back(r);
  endtask

  task automatic take_bit(input logic b);
    if (bit_cnt == 4'd0) begin
      if (!b) begin
        phase = TP_DONE;
        push_result(KIND_NO_START, 8'h00, 1'b1);
      end else begin
        bit_cnt = 4'd1;
        shreg   = 8'h00;
      end
    end else begin
      shreg = {shreg[6:0], b};
      if (phase == TP_DATA && b) ones_tot++;
      bit_cnt++;
      if (bit_cnt == 4'd9) begin
        bit_cnt = 4'd0;
        case (phase)
          TP_DATA: begin
            push_result(KIND_DATA, shreg, 1'b0);
            byte_cnt++;
            if (byte_cnt >= block_len_r) phase = TP_CSUM_HI;
          end
          TP_CSUM_HI: begin
            csum_hi = shreg;
            phase   = TP_CSUM_LO;
          end
          default: begin
            phase = TP_DONE;
            if ({csum_hi, shreg} == ones_tot) push_result(KIND_GOOD, 8'h00, 1'b1);
            else push_result(KIND_MISMATCH, 8'h00, 1'b1);
          end
        endcase
      end
    end
  endtask

  task automatic take_pulse(input logic [15:0] len);
    logic        is_long;
    logic [24:0] quot;
    is_long = (thresh != 16'd0) && (len >= thresh);
    case (phase)
      TP_SKIP: begin
        pulse_cnt++;
        if (pulse_cnt >= SKIP_PULSES) begin
          phase     = TP_SYNC;
          pulse_cnt = '0;
          len_sum   = '0;
        end
      end
      TP_SYNC: begin
        if (is_long) begin
          mark_cnt = '0;
          if (mark_len() > 8'd1) phase = TP_MARK_ONES;
          else phase = TP_MARK_ZEROS;
        end else begin
          len_sum = len_sum + 25'(len);
          pulse_cnt++;
          if (pulse_cnt >= SYNC_WINDOW) begin
            quot      = len_sum / SYNC_DIV;
            thresh    = (quot > 25'(LEN_MAX)) ? LEN_MAX : quot[15:0];
            len_sum   = '0;
            pulse_cnt = '0;
          end
        end
      end
      TP_MARK_ONES: begin
        if (!is_long) resync();
        else begin
          mark_cnt++;
          if (mark_cnt >= mark_len() - 8'd1) begin
            mark_cnt = '0;
            phase    = TP_MARK_ZEROS;
          end
        end
      end
      TP_MARK_ZEROS: begin
        if (is_long) resync();
        else begin
          mark_cnt++;
          if (mark_cnt >= mark_len()) begin
            mark_cnt = '0;
            phase    = TP_MARK_END;
          end
        end
      end
      TP_MARK_END: begin
        if (!is_long) resync();
        else begin
          byte_cnt = '0;
          bit_cnt  = '0;
          shreg    = '0;
          ones_tot = '0;
          if (block_len_r == 16'd0) phase = TP_CSUM_HI;
          else phase = TP_DATA;
        end
      end
      TP_DATA, TP_CSUM_HI, TP_CSUM_LO: take_bit(is_long);
      default: ;
    endcase
  endtask

  task automatic take_sample(input logic s, input logic r);
    logic [15:0] len;
    if (r) clear_decoder();
    if (s) begin
      if (low_seen) begin
        len      = hi_len;
        low_seen = 1'b0;
        hi_len   = 16'd1;
        if (phase != TP_DONE) take_pulse(len);
      end else if (hi_len != LEN_MAX) begin
        hi_len++;
      end
    end else begin
      low_seen = 1'b1;
    end
  endtask

  task automatic check_result(input cpbd_out_t got);
    cpbd_out_t want;
    checked++;
    if (expected_q.size() == 0) begin
      mism++;
      if (mism <= 10)
        $display("%0t: result with nothing expected: kind %0d byte %02h index %0d ones %0d last %0b",
                 $time, got.kind, got.data_byte, got.byte_index, got.ones_count, got.last);
    end else begin
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
          got.byte_index !== want.byte_index || got.ones_count !== want.ones_count ||
          got.last !== want.last) begin
        mism++;
        if (mism <= 10) begin
          $display("%0t: result mismatch", $time);
          $display("  expected kind %0d byte %02h index %0d ones %0d last %0b",
                   want.kind, want.data_byte, want.byte_index, want.ones_count, want.last);
          $display("  actual   kind %0d byte %02h index %0d ones %0d last %0b",
                   got.kind, got.data_byte, got.byte_index, got.ones_count, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_decoder();
      mark_len_r  = TAPEMARK_LENGTH_RESET;
      block_len_r = BLOCK_SIZE_RESET;
      expected_q.delete();
      mism        = 0;
      checked     = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TAPEMARK_LENGTH) mark_len_r = cfg_data[7:0];
        else block_len_r = cfg_data[15:0];
      end
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) take_sample(in_data.sample, in_data.restart);
    end
    err_count <= mism;
    pending   <= expected_q.size();
    n_checked <= checked;
  end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the cassette pulse block decoder. Drives well-formed tape
// blocks (lead-in, training, tapemark, data, checksum) with random content,
// broken blocks and line noise, under bursty input and a stalling receiver,
// across several register settings. The checker judges every result.
// ----------------------------------------------------------------------------
module tb_top import cpbd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SKIP_PULSES   = 256;
  localparam int SYNC_WINDOW   = 512;
  localparam int SAT_RUN       = 70000;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEM_GOAL     = 450;

  typedef enum {
    FAULT_NONE,
    FAULT_CSUM,
    FAULT_START,
    FAULT_MARK,
    FAULT_CUT
  } block_fault_e;

  typedef enum {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_e;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  cpbd_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  cpbd_out_t             out_data;
  logic                  cfg_we;
  logic [0:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int                    err_count;
  int                    pending;
  int                    n_checked;

  int                    burst_left;
  int                    n_sent;
  logic [7:0]            tm_len;
  logic [15:0]           blk_len;

  cassette_pulse_block_decoder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cpbd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .err_count (err_count),
    .pending   (pending),
    .n_checked (n_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one tape sample per item; bursts with gaps
  task automatic send_sample(input logic s, input logic r);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(100, 400);
      end else begin
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= '{sample: s, restart: r};
    do @(posedge clk); while (!in_ready);
    burst_left--;
    n_sent++;
  endtask

  task automatic send_pulse(input int hi, input int lo);
    repeat (hi) send_sample(1'b1, 1'b0);
    repeat (lo) send_sample(1'b0, 1'b0);
  endtask

  task automatic send_bit(input bit b, input int long_min, input int long_max);
    if (b) send_pulse($urandom_range(long_min, long_max), $urandom_range(1, 3));
    else send_pulse($urandom_range(1, 3), $urandom_range(1, 3));
  endtask

  task automatic send_byte(input logic [7:0] v, input int long_min, input int long_max);
    send_bit(1'b1, long_min, long_max);
    for (int i = 7; i >= 0; i--) send_bit(v[i], long_min, long_max);
  endtask

  // lead-in pulses, then a window of short pulses that sets the threshold;
  // the last lead-in pulses are short so a one-pulse shift keeps the window clean
  task automatic train(input bit sat);
    repeat (SKIP_PULSES - 4) send_pulse($urandom_range(1, 12), $urandom_range(1, 4));
    repeat (4) send_pulse(3, $urandom_range(1, 4));
    if (sat) send_pulse(SAT_RUN, 2);
    repeat (SYNC_WINDOW + $urandom_range(2, 8) - (sat ? 1 : 0))
      send_pulse(3, $urandom_range(1, 4));
  endtask

  task automatic run_block(input block_fault_e fault, input bit sat);
    int          long_min;
    int          long_max;
    int          marks;
    int          fault_at;
    int          n_data;
    logic [15:0] ones;
    logic [15:0] csum;
    logic [7:0]  v;
    long_min = sat ? 200 : 4;
    long_max = sat ? 210 : 8;
    marks    = (tm_len == 8'd0) ? 1 : tm_len;
    n_data   = blk_len;
    ones     = '0;
    csum     = '0;
    send_sample($urandom_range(0, 1), 1'b1);
    train(sat);
    if (fault == FAULT_MARK) begin
      fault_at = $urandom_range(1, 2 * marks);
      for (int i = 0; i < fault_at; i++) send_bit(i < marks, long_min, long_max);
      send_bit(!(fault_at < marks || fault_at == 2 * marks), long_min, long_max);
      train(1'b0);
    end
    for (int i = 0; i <= 2 * marks; i++)
      send_bit(i < marks || i == 2 * marks, long_min, long_max);
    if (n_data > 16) fault_at = $urandom_range(2, 5);
    else fault_at = $urandom_range(0, n_data + 1);
    for (int slot = 0; slot < n_data + 2; slot++) begin
      if (slot == n_data) begin
        csum = ones;
        if (fault == FAULT_CSUM) csum ^= 16'd1 << $urandom_range(0, 15);
      end
      if (slot == fault_at && fault == FAULT_CUT) break;
      if (slot == fault_at && fault == FAULT_START) begin
        send_bit(1'b0, long_min, long_max);
        break;
      end
      if (slot < n_data) begin
        case ($urandom_range(0, 7))
          0:       v = 8'h00;
          1:       v = 8'hFF;
          default: v = 8'($urandom);
        endcase
        ones += 16'($countones(v));
      end else begin
        v = (slot == n_data) ? csum[15:8] : csum[7:0];
      end
      send_byte(v, long_min, long_max);
    end
    send_sample(1'b1, 1'b0);
    repeat ($urandom_range(0, 10)) send_sample($urandom_range(0, 1), 1'b0);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(50, 300))
      send_sample($urandom_range(0, 1), $urandom_range(0, 40) == 0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cpbd_cfg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_TAPEMARK_LENGTH) tm_len = val[7:0];
    else blk_len = val;
  endtask

  // receiver: own stall pattern, plus one long hold-off once data is flowing
  initial begin : receiver
    rx_mode_e mode;
    int       tick;
    int       hold;
    bit       held;
    out_ready <= 1'b0;
    mode = RX_OPEN;
    tick = 0;
    hold = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && n_checked >= 5) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (tick % 64 == 0) mode = rx_mode_e'($urandom_range(0, 3));
      tick++;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:     out_ready <= 1'b1;
          RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: out_ready <= (tick % 4 != 0);
          default:     out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    block_fault_e fault;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    rst_n      <= 1'b0;
    burst_left = 0;
    n_sent     = 0;
    tm_len     = TAPEMARK_LENGTH_RESET;
    blk_len    = BLOCK_SIZE_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values, long data run under the receiver hold-off
    run_block(FAULT_NONE, 1'b0);
    // zero tapemark length and checksum straight after the tapemark
    settle();
    write_reg(CFG_TAPEMARK_LENGTH, 16'd0);
    write_reg(CFG_BLOCK_SIZE, 16'd0);
    run_block(FAULT_NONE, 1'b0);
    // longest tapemark, single byte, bad checksum
    settle();
    write_reg(CFG_TAPEMARK_LENGTH, 16'd255);
    write_reg(CFG_BLOCK_SIZE, 16'd1);
    run_block(FAULT_CSUM, 1'b0);
    // largest block cut short by a missing start bit
    settle();
    write_reg(CFG_TAPEMARK_LENGTH, 16'd1);
    write_reg(CFG_BLOCK_SIZE, 16'hFFFF);
    run_block(FAULT_START, 1'b0);
    // saturated high run in the training window, then a tapemark error
    settle();
    write_reg(CFG_TAPEMARK_LENGTH, 16'd2);
    write_reg(CFG_BLOCK_SIZE, 16'd3);
    run_block(FAULT_MARK, 1'b1);
    send_noise();

    while (n_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 7) == 0) begin
        send_noise();
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          settle();
          write_reg(CFG_TAPEMARK_LENGTH,
                    ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4)));
          write_reg(CFG_BLOCK_SIZE, 16'($urandom_range(0, 8)));
        end
        case ($urandom_range(0, 9))
          5:       fault = FAULT_CSUM;
          6:       fault = FAULT_START;
          7:       fault = FAULT_MARK;
          8:       fault = FAULT_CUT;
          default: fault = FAULT_NONE;
        endcase
        run_block(fault, 1'b0);
      end
    end

    settle();
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
